>>> src/atba_pkg.sv
// ----------------------------------------------------------------------------
// atba_pkg: shared definitions for the aligned tile bitmap allocator
// Grid size, field widths, register indexes and the row store request type.
// ----------------------------------------------------------------------------
`default_nettype none

package atba_pkg;

   // Grid edge in cells, and the widths that follow from it
   localparam int GRID_CELLS = 32;
   localparam int CELL_IDX_W = $clog2(GRID_CELLS);
   localparam int CELL_CNT_W = $clog2(GRID_CELLS + 1);

   // Field and register widths
   localparam int RES_W  = 17;
   localparam int MT_W   = 13;
   localparam int TILE_W = 17;
   localparam int POS_W  = 16;
   localparam int CSR_W  = 17;

   // Register indexes
   localparam logic CSR_ATLAS_RES = 1'b0;
   localparam logic CSR_MIN_TILE  = 1'b1;

   // Register reset values and resolution ceiling
   localparam logic [RES_W-1:0] ATLAS_RES_RESET = RES_W'(4096);
   localparam logic [MT_W-1:0]  MIN_TILE_RESET  = MT_W'(128);
   localparam logic [RES_W-1:0] ATLAS_RES_MAX   = RES_W'(65536);

   // Commands
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   // Request from the controller to the occupancy row store
   typedef struct packed {
      logic                  clear;
      logic                  rd_en;
      logic [CELL_IDX_W-1:0] rd_addr;
      logic                  wr_en;
      logic [CELL_IDX_W-1:0] wr_addr;
      logic [GRID_CELLS-1:0] wr_data;
   } row_req_type;

endpackage

`default_nettype wire

>>> src/atba_div.sv
// ----------------------------------------------------------------------------
// atba_div: restoring divider
// Unsigned 17-bit by 13-bit division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module atba_div (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [atba_pkg::RES_W-1:0]   dividend,
   input  wire logic [atba_pkg::MT_W-1:0]    divisor,   // never zero
   output logic                              done,
   output logic [atba_pkg::RES_W-1:0]        quotient
);

   localparam int CNT_W = $clog2(atba_pkg::RES_W + 1);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic [atba_pkg::MT_W-1:0]    rem_ff, rem_in;
   logic [atba_pkg::RES_W-1:0]   quo_ff, quo_in;
   logic [atba_pkg::MT_W-1:0]    dvs_ff, dvs_in;
   logic [atba_pkg::MT_W:0]      trial;
   logic [atba_pkg::MT_W:0]      diff;
   logic                         ge;

   // One shift-subtract step
   always_comb begin
      trial = {rem_ff, quo_ff[atba_pkg::RES_W-1]};
      ge    = (trial >= {1'b0, dvs_ff});
      diff  = trial - {1'b0, dvs_ff};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(atba_pkg::RES_W - 1);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[atba_pkg::MT_W-1:0] : trial[atba_pkg::MT_W-1:0];
         quo_in = {quo_ff[atba_pkg::RES_W-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

>>> src/atba_rows.sv
// ----------------------------------------------------------------------------
// atba_rows: occupancy row store
// One row of cell bits per entry, synchronous read with the data registered
// and valid in the cycle after the request. Per-row valid flops make a clear
// take effect at once; an invalid row reads as all cells free.
// ----------------------------------------------------------------------------
`default_nettype none

module atba_rows (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire atba_pkg::row_req_type             req,
   output logic [atba_pkg::GRID_CELLS-1:0]        rd_data
);

   logic [atba_pkg::GRID_CELLS-1:0] mem [atba_pkg::GRID_CELLS];
   logic [atba_pkg::GRID_CELLS-1:0] valid_ff, valid_in;
   logic [atba_pkg::GRID_CELLS-1:0] rd_q_ff;
   logic                            rd_vld_ff;

   // Valid bits: clear drops all, a write sets its row
   always_comb begin
      valid_in = valid_ff;
      if (req.clear) begin
         valid_in = '0;
      end else if (req.wr_en) begin
         valid_in[req.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Row array, written and read in clocked blocks
   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (req.rd_en) begin
         rd_q_ff   <= mem[req.rd_addr];
         rd_vld_ff <= valid_ff[req.rd_addr];
      end
   end

   assign rd_data = rd_vld_ff ? rd_q_ff : '0;

endmodule

`default_nettype wire

>>> src/aligned_tile_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// aligned_tile_bitmap_allocator: square tile placement over an occupancy grid
// Controller, configuration registers and result register of the allocator.
// ----------------------------------------------------------------------------
// A clear transaction frees the whole grid at once through per-row valid
// bits; no clearing pass follows reset. An allocate transaction runs two
// divisions (grid size, then span) through one shared divider, then scans
// bands of span rows: each band has a setup step, reads of its span rows from
// the row store folded into one mask, a check of each aligned candidate column
// in turn and a step to leave the band. A placement adds a read-modify-write
// of each of its span rows, a step to form the position and one to load the
// output register. One item is in work at a time; the next is taken while the
// previous result waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module aligned_tile_bitmap_allocator (
   input  wire logic         clock,
   input  wire logic         reset,
   // configuration port
   input  wire logic         csr_we,
   input  wire logic         csr_addr,
   input  wire logic [16:0]  csr_wdata,
   // request channel
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [23:0]  req_tdata,   // [16:0] tile_size, rest zero
   input  wire logic         req_tuser,   // [0] cmd
   // response channel
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [31:0]       rsp_tdata,   // [15:0] pos_x, [31:16] pos_y
   output logic              rsp_tuser    // [0] ok
);

   localparam int CNT_W = atba_pkg::CELL_CNT_W;
   localparam int IDX_W = atba_pkg::CELL_IDX_W;
   localparam int GC    = atba_pkg::GRID_CELLS;
   localparam int PROD_W = CNT_W + atba_pkg::MT_W;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV_CELLS,
      ST_DIV_SPAN,
      ST_BAND,
      ST_BAND_RD,
      ST_BAND_ACC,
      ST_X_SCAN,
      ST_MARK_RD,
      ST_MARK_WR,
      ST_POS,
      ST_DONE
   } state_type;

   // Mask of n low ones, n up to the grid size
   function automatic logic [GC-1:0] span_mask(input logic [CNT_W-1:0] n);
      logic [GC:0] m;
      m = ({{GC{1'b0}}, 1'b1} << n) - {{GC{1'b0}}, 1'b1};
      return m[GC-1:0];
   endfunction

   state_type                      state_ff, state_in;
   logic [atba_pkg::RES_W-1:0]     atlas_res_ff, atlas_res_in;
   logic [atba_pkg::MT_W-1:0]      min_tile_ff, min_tile_in;
   logic [atba_pkg::MT_W-1:0]      mt_ff, mt_in;
   logic [atba_pkg::TILE_W-1:0]    tile_ff, tile_in;
   logic [CNT_W-1:0]               cells_ff, cells_in;
   logic [CNT_W-1:0]               span_ff, span_in;
   logic [CNT_W-1:0]               x_ff, x_in;
   logic [CNT_W-1:0]               y_ff, y_in;
   logic [CNT_W-1:0]               row_ptr_ff, row_ptr_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic [GC-1:0]                  acc_ff, acc_in;
   logic                           res_ok_ff, res_ok_in;
   logic [atba_pkg::POS_W-1:0]     res_x_ff, res_x_in;
   logic [atba_pkg::POS_W-1:0]     res_y_ff, res_y_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_ok_ff, rsp_ok_in;
   logic [atba_pkg::POS_W-1:0]     rsp_x_ff, rsp_x_in;
   logic [atba_pkg::POS_W-1:0]     rsp_y_ff, rsp_y_in;

   logic                           req_fire;
   logic [atba_pkg::RES_W-1:0]     res_sat;
   logic [atba_pkg::MT_W-1:0]      mt_eff;
   logic                           div_start;
   logic [atba_pkg::RES_W-1:0]     div_dividend;
   logic [atba_pkg::MT_W-1:0]      div_divisor;
   logic                           div_done;
   logic [atba_pkg::RES_W-1:0]     div_quo;
   atba_pkg::row_req_type          row_req;
   logic [GC-1:0]                  row_data;
   logic [CNT_W:0]                 y_end;
   logic [CNT_W:0]                 x_end;
   logic [GC-1:0]                  smask;
   logic [GC-1:0]                  window;
   logic [GC-1:0]                  mark_bits;
   logic [PROD_W-1:0]              prod_x;
   logic [PROD_W-1:0]              prod_y;
   logic                           rsp_load;

   // Configuration registers
   always_comb begin
      atlas_res_in = atlas_res_ff;
      min_tile_in  = min_tile_ff;
      if (csr_we) begin
         case (csr_addr)
            atba_pkg::CSR_ATLAS_RES: atlas_res_in = csr_wdata[atba_pkg::RES_W-1:0];
            atba_pkg::CSR_MIN_TILE:  min_tile_in  = csr_wdata[atba_pkg::MT_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective registers
   assign res_sat = (atlas_res_ff > atba_pkg::ATLAS_RES_MAX) ? atba_pkg::ATLAS_RES_MAX
                                                             : atlas_res_ff;
   assign mt_eff  = (min_tile_ff == '0) ? atba_pkg::MT_W'(1) : min_tile_ff;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // Scan datapath
   always_comb begin
      y_end     = {1'b0, y_ff} + {1'b0, span_ff};
      x_end     = {1'b0, x_ff} + {1'b0, span_ff};
      smask     = span_mask(span_ff);
      window    = (acc_ff >> x_ff) & smask;
      mark_bits = smask << x_ff;
      prod_x    = PROD_W'(x_ff) * PROD_W'(mt_ff);
      prod_y    = PROD_W'(y_ff) * PROD_W'(mt_ff);
      rsp_load  = !rsp_valid_ff || rsp_tready;
   end

   // Controller
   always_comb begin
      state_in     = state_ff;
      mt_in        = mt_ff;
      tile_in      = tile_ff;
      cells_in     = cells_ff;
      span_in      = span_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      row_ptr_in   = row_ptr_ff;
      cnt_in       = cnt_ff;
      acc_in       = acc_ff;
      res_ok_in    = res_ok_ff;
      res_x_in     = res_x_ff;
      res_y_in     = res_y_ff;
      div_start    = 1'b0;
      div_dividend = res_sat;
      div_divisor  = mt_eff;
      row_req      = '0;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               res_x_in = '0;
               res_y_in = '0;
               if (req_tuser == atba_pkg::CMD_CLEAR) begin
                  row_req.clear = 1'b1;
                  res_ok_in     = 1'b1;
                  state_in      = ST_DONE;
               end else begin
                  res_ok_in = 1'b0;
                  mt_in     = mt_eff;
                  tile_in   = req_tdata[atba_pkg::TILE_W-1:0];
                  div_start = 1'b1;
                  state_in  = ST_DIV_CELLS;
               end
            end
         end
         ST_DIV_CELLS: begin
            if (div_done) begin
               if (div_quo == '0) begin
                  cells_in = CNT_W'(1);
               end else if (div_quo > atba_pkg::RES_W'(GC)) begin
                  cells_in = CNT_W'(GC);
               end else begin
                  cells_in = div_quo[CNT_W-1:0];
               end
               div_start    = 1'b1;
               div_dividend = tile_ff;
               div_divisor  = mt_ff;
               state_in     = ST_DIV_SPAN;
            end
         end
         ST_DIV_SPAN: begin
            if (div_done) begin
               if (div_quo > atba_pkg::RES_W'(cells_ff)) begin
                  state_in = ST_DONE;
               end else begin
                  span_in  = (div_quo == '0) ? CNT_W'(1) : div_quo[CNT_W-1:0];
                  y_in     = '0;
                  state_in = ST_BAND;
               end
            end
         end
         // Start a band of span rows, or give up past the last one
         ST_BAND: begin
            if (y_end > {1'b0, cells_ff}) begin
               state_in = ST_DONE;
            end else begin
               acc_in     = '0;
               row_ptr_in = y_ff;
               cnt_in     = '0;
               state_in   = ST_BAND_RD;
            end
         end
         ST_BAND_RD: begin
            row_req.rd_en   = 1'b1;
            row_req.rd_addr = row_ptr_ff[IDX_W-1:0];
            state_in        = ST_BAND_ACC;
         end
         // Fold the band's rows into one mask
         ST_BAND_ACC: begin
            acc_in     = acc_ff | row_data;
            row_ptr_in = row_ptr_ff + CNT_W'(1);
            cnt_in     = cnt_ff + CNT_W'(1);
            if (cnt_ff == span_ff - CNT_W'(1)) begin
               x_in     = '0;
               state_in = ST_X_SCAN;
            end else begin
               state_in = ST_BAND_RD;
            end
         end
         // One aligned candidate column per cycle
         ST_X_SCAN: begin
            if (x_end > {1'b0, cells_ff}) begin
               y_in     = y_end[CNT_W-1:0];
               state_in = ST_BAND;
            end else if (window == '0) begin
               row_ptr_in = y_ff;
               cnt_in     = '0;
               state_in   = ST_MARK_RD;
            end else begin
               x_in = x_end[CNT_W-1:0];
            end
         end
         ST_MARK_RD: begin
            row_req.rd_en   = 1'b1;
            row_req.rd_addr = row_ptr_ff[IDX_W-1:0];
            state_in        = ST_MARK_WR;
         end
         ST_MARK_WR: begin
            row_req.wr_en   = 1'b1;
            row_req.wr_addr = row_ptr_ff[IDX_W-1:0];
            row_req.wr_data = row_data | mark_bits;
            row_ptr_in      = row_ptr_ff + CNT_W'(1);
            cnt_in          = cnt_ff + CNT_W'(1);
            if (cnt_ff == span_ff - CNT_W'(1)) begin
               state_in = ST_POS;
            end else begin
               state_in = ST_MARK_RD;
            end
         end
         ST_POS: begin
            res_ok_in = 1'b1;
            res_x_in  = prod_x[atba_pkg::POS_W-1:0];
            res_y_in  = prod_y[atba_pkg::POS_W-1:0];
            state_in  = ST_DONE;
         end
         // Hand the result to the output register once it is free
         ST_DONE: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = res_ok_ff;
               rsp_x_in     = res_x_ff;
               rsp_y_in     = res_y_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         atlas_res_ff <= atba_pkg::ATLAS_RES_RESET;
         min_tile_ff  <= atba_pkg::MIN_TILE_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         atlas_res_ff <= atlas_res_in;
         min_tile_ff  <= min_tile_in;
      end
      mt_ff      <= mt_in;
      tile_ff    <= tile_in;
      cells_ff   <= cells_in;
      span_ff    <= span_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      row_ptr_ff <= row_ptr_in;
      cnt_ff     <= cnt_in;
      acc_ff     <= acc_in;
      res_ok_ff  <= res_ok_in;
      res_x_ff   <= res_x_in;
      res_y_ff   <= res_y_in;
      rsp_ok_ff  <= rsp_ok_in;
      rsp_x_ff   <= rsp_x_in;
      rsp_y_ff   <= rsp_y_in;
   end

   // Shared divider
   atba_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Occupancy row store
   atba_rows u_rows (
      .clock   (clock),
      .reset   (reset),
      .req     (row_req),
      .rd_data (row_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ok_ff;
   assign rsp_tdata  = {rsp_y_ff, rsp_x_ff};

   // Every row write is the write-back of the row read just before
   a_rmw_pair: assert property (@(posedge clock) disable iff (reset)
      row_req.wr_en |-> $past(row_req.rd_en) && ($past(row_req.rd_addr) == row_req.wr_addr))
      else $error("row write without matching read");

   // Marked rows lie inside the current grid
   a_wr_in_grid: assert property (@(posedge clock) disable iff (reset)
      row_req.wr_en |-> ({1'b0, row_req.wr_addr} < cells_ff))
      else $error("row write outside grid");

   // A clear never overlaps a row access
   a_clear_alone: assert property (@(posedge clock) disable iff (reset)
      row_req.clear |-> !row_req.rd_en && !row_req.wr_en)
      else $error("clear overlaps row access");

   // Divider results arrive only while the controller waits for them
   a_div_expected: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV_CELLS) || (state_ff == ST_DIV_SPAN))
      else $error("unexpected divider result");

   // A failed allocation reports position zero
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> (rsp_tdata == '0))
      else $error("failed result with nonzero position");

endmodule

`default_nettype wire

>>> tb/sv/tb_aligned_tile_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// tb_aligned_tile_bitmap_allocator: self-checking bench for the tile allocator
// Drives allocate and clear transactions under several atlas settings, keeps
// its own copy of the occupancy grid to work out every placement, and checks
// each response field by field in order, with random sender and receiver gaps.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_aligned_tile_bitmap_allocator;

   timeunit 1ns;
   timeprecision 1ps;

   // One response: placement flag and pixel corner
   typedef struct packed {
      logic                       ok;
      logic [atba_pkg::POS_W-1:0] pos_x;
      logic [atba_pkg::POS_W-1:0] pos_y;
   } placement_type;

   // One row of the directed table; want is used only where typed is set
   typedef struct packed {
      logic                        cmd;
      logic [atba_pkg::TILE_W-1:0] tile;
      logic                        typed;
      placement_type               want;
   } directed_row_type;

   localparam int NUM_DIRECTED = 18;
   localparam int NUM_SETTINGS = 8;
   localparam int ITEMS_PER_SETTING = 108;
   localparam int MAX_TILE = 65536;

   logic                       clock;
   logic                       reset      = 1'b1;
   logic                       csr_we     = 1'b0;
   logic                       csr_addr   = atba_pkg::CSR_ATLAS_RES;
   logic [atba_pkg::CSR_W-1:0] csr_wdata  = '0;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [23:0]                req_tdata  = '0;   // [16:0] tile_size, rest zero
   logic                       req_tuser  = atba_pkg::CMD_ALLOC;   // [0] cmd
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [31:0]                rsp_tdata;         // [15:0] pos_x, [31:16] pos_y
   logic                       rsp_tuser;         // [0] ok

   // Shadow of the block: registers and occupancy grid, row-major
   logic [atba_pkg::RES_W-1:0]    atlas_res = atba_pkg::ATLAS_RES_RESET;
   logic [atba_pkg::MT_W-1:0]     min_tile  = atba_pkg::MIN_TILE_RESET;
   bit [atba_pkg::GRID_CELLS-1:0] occupancy [atba_pkg::GRID_CELLS];

   placement_type expected_placements [$];
   int unsigned mismatch_count = 0;
   int unsigned send_idle_pct  = 0;
   int unsigned stall_pct      = 0;

   // Atlas settings walked by the random part, extremes included
   logic [atba_pkg::CSR_W-1:0] res_settings [NUM_SETTINGS] = '{
      17'd4096, 17'd256, 17'h1FFFF, 17'd1, 17'd65536, 17'd100, 17'd96, 17'd65536};
   logic [atba_pkg::CSR_W-1:0] mt_settings [NUM_SETTINGS] = '{
      17'd128, 17'd32, 17'd4096, 17'd8191, 17'd1, 17'd0, 17'd16, 17'h1F800};

   aligned_tile_bitmap_allocator i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Run limit
   initial begin
      #20_000_000;
      $display("simulation failed");
      $finish;
   end

   // Cell edge in pixels; zero counts as one
   function automatic int unsigned cell_pixels();
      return (min_tile == '0) ? 1 : int'(min_tile);
   endfunction

   // Grid edge in cells from the current registers
   function automatic int unsigned grid_edge();
      int unsigned res;
      int unsigned cells;
      res = (atlas_res > atba_pkg::ATLAS_RES_MAX) ? int'(atba_pkg::ATLAS_RES_MAX)
                                                  : int'(atlas_res);
      cells = res / cell_pixels();
      if (cells < 1) cells = 1;
      if (cells > atba_pkg::GRID_CELLS) cells = atba_pkg::GRID_CELLS;
      return cells;
   endfunction

   // Apply one transaction to the shadow grid and return its response
   function automatic placement_type place_tile(input logic cmd,
                                                input logic [atba_pkg::TILE_W-1:0] tile);
      placement_type r;
      int unsigned   mt;
      int unsigned   cells;
      int unsigned   span;
      bit            free;
      r = '0;
      if (cmd == atba_pkg::CMD_CLEAR) begin
         foreach (occupancy[j]) occupancy[j] = '0;
         r.ok = 1'b1;
         return r;
      end
      mt = cell_pixels();
      cells = grid_edge();
      span = int'(tile) / mt;
      if (span < 1) span = 1;
      if (span > cells) return r;
      // aligned candidates, row by row, left to right
      for (int unsigned y = 0; y + span <= cells; y += span) begin
         for (int unsigned x = 0; x + span <= cells; x += span) begin
            free = 1'b1;
            for (int unsigned j = 0; j < span; j++)
               for (int unsigned i = 0; i < span; i++)
                  if (occupancy[y + j][x + i]) free = 1'b0;
            if (free) begin
               for (int unsigned j = 0; j < span; j++)
                  for (int unsigned i = 0; i < span; i++)
                     occupancy[y + j][x + i] = 1'b1;
               r.ok = 1'b1;
               r.pos_x = atba_pkg::POS_W'(x * mt);
               r.pos_y = atba_pkg::POS_W'(y * mt);
               return r;
            end
         end
      end
      return r;
   endfunction

   // Present one request, wait for its handshake, then record the expectation
   task automatic send_item(input logic cmd, input logic [atba_pkg::TILE_W-1:0] tile,
                            input logic typed, input placement_type want);
      placement_type predicted;
      placement_type entry;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {7'b0, tile};
      do @(posedge clock); while (!req_tready);
      predicted = place_tile(cmd, tile);
      entry = typed ? want : predicted;
      expected_placements = {expected_placements, entry};
   endtask

   // Stop sending and wait until every response is back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_placements.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write both atlas registers; block must be idle
   task automatic set_atlas(input logic [atba_pkg::CSR_W-1:0] res_val,
                            input logic [atba_pkg::CSR_W-1:0] mt_val);
      csr_we    <= 1'b1;
      csr_addr  <= atba_pkg::CSR_ATLAS_RES;
      csr_wdata <= res_val;
      @(posedge clock);
      csr_addr  <= atba_pkg::CSR_MIN_TILE;
      csr_wdata <= mt_val;
      @(posedge clock);
      csr_we    <= 1'b0;
      atlas_res = res_val[atba_pkg::RES_W-1:0];
      min_tile  = mt_val[atba_pkg::MT_W-1:0];
   endtask

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // Response checker
   always @(posedge clock) begin
      placement_type got;
      placement_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.ok    = rsp_tuser;
         got.pos_x = rsp_tdata[15:0];
         got.pos_y = rsp_tdata[31:16];
         if (expected_placements.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: response with nothing expected: ok=%0b x=%0d y=%0d",
                        $realtime, got.ok, got.pos_x, got.pos_y);
         end else begin
            want = expected_placements.pop_front();
            if (got.ok !== want.ok || got.pos_x !== want.pos_x
                || got.pos_y !== want.pos_y) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: mismatch: expected ok=%0b x=%0d y=%0d, got ok=%0b x=%0d y=%0d",
                           $realtime, want.ok, want.pos_x, want.pos_y,
                           got.ok, got.pos_x, got.pos_y);
            end
         end
      end
   end

   // Stimulus
   initial begin
      directed_row_type directed_rows [NUM_DIRECTED];
      int unsigned      mt;
      int unsigned      cells;
      int unsigned      span;
      int unsigned      pick;
      int unsigned      tile_val;
      int unsigned      idx;

      foreach (occupancy[j]) occupancy[j] = '0;

      // Reset grid: 32 cells of 128 pixels
      directed_rows = '{
         '{atba_pkg::CMD_ALLOC, 17'd0,     1'b1, '{1'b1, 16'd0,   16'd0}},  // first cell
         '{atba_pkg::CMD_ALLOC, 17'd128,   1'b1, '{1'b1, 16'd128, 16'd0}},  // next cell right
         '{atba_pkg::CMD_ALLOC, 17'd65536, 1'b1, '{1'b0, 16'd0,   16'd0}},  // far too big
         '{atba_pkg::CMD_ALLOC, 17'd4096,  1'b1, '{1'b0, 16'd0,   16'd0}},  // whole grid, taken
         '{atba_pkg::CMD_CLEAR, 17'd0,     1'b1, '{1'b1, 16'd0,   16'd0}},
         '{atba_pkg::CMD_ALLOC, 17'd4096,  1'b1, '{1'b1, 16'd0,   16'd0}},  // whole grid, free
         '{atba_pkg::CMD_ALLOC, 17'd0,     1'b1, '{1'b0, 16'd0,   16'd0}},  // grid full
         '{atba_pkg::CMD_CLEAR, 17'h1FFFF, 1'b1, '{1'b1, 16'd0,   16'd0}},
         '{atba_pkg::CMD_ALLOC, 17'd127,   1'b1, '{1'b1, 16'd0,   16'd0}},  // below min tile
         '{atba_pkg::CMD_ALLOC, 17'd256,   1'b1, '{1'b1, 16'd256, 16'd0}},  // span 2 skips cell 0
         '{atba_pkg::CMD_ALLOC, 17'd1024,  1'b0, '0},
         '{atba_pkg::CMD_ALLOC, 17'd2048,  1'b0, '0},
         '{atba_pkg::CMD_ALLOC, 17'd2048,  1'b0, '0},
         '{atba_pkg::CMD_ALLOC, 17'd2048,  1'b0, '0},
         '{atba_pkg::CMD_ALLOC, 17'd2048,  1'b1, '{1'b0, 16'd0,   16'd0}},  // no span-16 slot
         '{atba_pkg::CMD_ALLOC, 17'd65535, 1'b1, '{1'b0, 16'd0,   16'd0}},
         '{atba_pkg::CMD_ALLOC, 17'd255,   1'b1, '{1'b1, 16'd128, 16'd0}},  // gap at x=1
         '{atba_pkg::CMD_CLEAR, 17'd65536, 1'b1, '{1'b1, 16'd0,   16'd0}}
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part under the reset settings
      foreach (directed_rows[k])
         send_item(directed_rows[k].cmd, directed_rows[k].tile,
                   directed_rows[k].typed, directed_rows[k].want);

      // Random part: four idling phases, four atlas settings each
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 69; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 69; end
            default: begin send_idle_pct = 35; stall_pct = 35; end
         endcase
         for (int sub = 0; sub < 4; sub++) begin
            drain();
            idx = (ph * 4 + sub + ph) % NUM_SETTINGS;
            set_atlas(res_settings[idx], mt_settings[idx]);
            for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
               mt = cell_pixels();
               cells = grid_edge();
               if ($urandom_range(99) < 10) begin
                  send_item(atba_pkg::CMD_CLEAR,
                            atba_pkg::TILE_W'($urandom_range(MAX_TILE)), 1'b0, '0);
               end else begin
                  pick = $urandom_range(99);
                  if (pick < 15) begin
                     tile_val = $urandom_range(mt - 1);
                  end else begin
                     if (pick < 45) span = 1;
                     else if (pick < 70) span = $urandom_range(1) ? 2 : 4;
                     else if (pick < 88) span = $urandom_range(cells + 1, 1);
                     else span = 0;
                     // span zero: any size from zero to MAX_TILE
                     tile_val = (span == 0) ? $urandom_range(MAX_TILE)
                                            : span * mt + $urandom_range(mt - 1);
                  end
                  if (tile_val > MAX_TILE) tile_val = MAX_TILE;
                  send_item(atba_pkg::CMD_ALLOC, atba_pkg::TILE_W'(tile_val), 1'b0, '0);
               end
            end
         end
      end

      // Wind down: all responses back, then watch for strays
      drain();
      repeat (1200) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> sim.f
src/atba_pkg.sv
src/atba_div.sv
src/atba_rows.sv
src/aligned_tile_bitmap_allocator.sv
tb/sv/tb_aligned_tile_bitmap_allocator.sv
